// File: rtl/sao_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sample adaptive offset filter unit.
// No dependencies.
package sao_pkg;

    localparam int PIX_W = 10;
    localparam logic [PIX_W-1:0] PIX_MAX = 10'h3FF;
    localparam int BAND_SHIFT = 10 - 5;
    localparam logic [4:0] BAND_MASK = 5'd31;
    localparam int OFS_W = 8;
    localparam int NUM_OFS = 4;

    // Register indexes on the configuration port (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_SAO_MODE    = 3'd0,
        REG_EDGE_CLASS  = 3'd1,
        REG_BAND_START  = 3'd2,
        REG_OFFSET_CAT0 = 3'd3,
        REG_OFFSET_CAT1 = 3'd4,
        REG_OFFSET_CAT2 = 3'd5,
        REG_OFFSET_CAT3 = 3'd6,
        REG_ROW_WIDTH   = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        EDGE_HOR  = 2'd0,
        EDGE_VER  = 2'd1,
        EDGE_DR   = 2'd2,
        EDGE_DL   = 2'd3
    } t_edge_class;

    typedef logic signed [OFS_W-1:0] t_offset;

endpackage

// File: rtl/sample_adaptive_offset_filter_unit.sv
`timescale 1ns / 1ps
// Sample adaptive offset filter, 10-bit samples, band and edge modes.
// Depends on sao_pkg.
//
// Usage:
//   Slave stream (i_s_*) carries one sample per word in raster order; tlast marks
//   the last sample of a block and restarts the column and row counters.
//   Master stream (o_m_*) carries the corrected sample; tlast follows the tlast of
//   the input word that produced it. Band mode gives one result per word. Edge
//   mode expects the block with a one-sample border; border words give no result,
//   and each interior sample comes out when the word one row below and one column
//   right of it arrives.
//   Pipeline: two register stages, stage 1 and the output register. Throughput:
//   one word per cycle while the master side takes results, set by the one-read
//   one-write line buffer memory that is read at accept and written back as the word
//   leaves stage 1; a repeated column address is forwarded from the write port.
//   A stalled master side holds its output register; the slave side keeps
//   accepting until the stage in front of the output register is also full.
//   Reset (synchronous, active low) clears counters, window and configuration;
//   line buffers are not cleared and need no clearing pass.
//   The APB-style port writes registers at byte address 4*index; write only
//   while the block is idle.
module sample_adaptive_offset_filter_unit #(
    parameter int MAX_ROW_WIDTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [9:0] pixel_in, [15:10] zero
    input  logic        i_s_tlast,   // block_end
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [9:0] pixel_out, [15:10] zero
    output logic        o_m_tlast,   // result_last
    // configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int AW = $clog2(MAX_ROW_WIDTH);
    localparam int WW = (AW + 1 > 9) ? AW + 1 : 9;
    localparam int RST_W = (256 < MAX_ROW_WIDTH) ? 256 : MAX_ROW_WIDTH;
    localparam logic [AW-1:0] RST_LAST = AW'(RST_W - 1);
    localparam logic [AW-1:0] MAX_LAST = AW'(MAX_ROW_WIDTH - 1);
    localparam int PW = sao_pkg::PIX_W;

    // ---------------- configuration ----------------
    logic                 r_mode;
    logic [1:0]           r_edge_class;
    logic [4:0]           r_band_start;
    sao_pkg::t_offset     r_offset [sao_pkg::NUM_OFS];
    logic [8:0]           r_row_width;
    logic [AW-1:0]        r_eff_last;
    logic [AW-1:0]        n_eff_last;
    logic                 cfg_wr;
    logic [WW-1:0]        wr_width;
    sao_pkg::t_reg_idx    cfg_idx;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel & i_penable & i_pwrite;
    assign cfg_idx  = sao_pkg::t_reg_idx'(i_paddr[4:2]);
    assign wr_width = WW'(i_pwdata[8:0]);

    always_comb begin
        if (wr_width < WW'(3)) begin
            n_eff_last = AW'(2);
        end else if (wr_width > WW'(MAX_ROW_WIDTH)) begin
            n_eff_last = MAX_LAST;
        end else begin
            n_eff_last = AW'(wr_width - WW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_edge_class <= 2'd0;
            r_band_start <= 5'd0;
            for (int i = 0; i < sao_pkg::NUM_OFS; i++) r_offset[i] <= '0;
            r_row_width  <= 9'd256;
            r_eff_last   <= RST_LAST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                sao_pkg::REG_SAO_MODE:    r_mode       <= i_pwdata[0];
                sao_pkg::REG_EDGE_CLASS:  r_edge_class <= i_pwdata[1:0];
                sao_pkg::REG_BAND_START:  r_band_start <= i_pwdata[4:0];
                sao_pkg::REG_OFFSET_CAT0: r_offset[0]  <= i_pwdata[7:0];
                sao_pkg::REG_OFFSET_CAT1: r_offset[1]  <= i_pwdata[7:0];
                sao_pkg::REG_OFFSET_CAT2: r_offset[2]  <= i_pwdata[7:0];
                sao_pkg::REG_OFFSET_CAT3: r_offset[3]  <= i_pwdata[7:0];
                sao_pkg::REG_ROW_WIDTH: begin
                    r_row_width <= i_pwdata[8:0];
                    r_eff_last  <= n_eff_last;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            sao_pkg::REG_SAO_MODE:    o_prdata = {31'd0, r_mode};
            sao_pkg::REG_EDGE_CLASS:  o_prdata = {30'd0, r_edge_class};
            sao_pkg::REG_BAND_START:  o_prdata = {27'd0, r_band_start};
            sao_pkg::REG_OFFSET_CAT0: o_prdata = {24'd0, r_offset[0]};
            sao_pkg::REG_OFFSET_CAT1: o_prdata = {24'd0, r_offset[1]};
            sao_pkg::REG_OFFSET_CAT2: o_prdata = {24'd0, r_offset[2]};
            sao_pkg::REG_OFFSET_CAT3: o_prdata = {24'd0, r_offset[3]};
            sao_pkg::REG_ROW_WIDTH:   o_prdata = {23'd0, r_row_width};
            default:                  o_prdata = 32'd0;
        endcase
    end

    // ---------------- position counters (accept stage) ----------------
    logic              s_acc;
    logic [AW-1:0]     r_col;
    logic [1:0]        r_row;
    logic [AW-1:0]     acc_x;
    logic              acc_edge_ok;

    assign s_acc = i_s_tvalid & o_s_tready;
    assign acc_x = (r_col > r_eff_last) ? r_eff_last : r_col;
    assign acc_edge_ok = (r_row == 2'd2) && (acc_x > AW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= 2'd0;
        end else if (s_acc) begin
            if (i_s_tlast) begin
                r_col <= '0;
                r_row <= 2'd0;
            end else if (acc_x == r_eff_last) begin
                r_col <= '0;
                if (r_row != 2'd2) r_row <= r_row + 2'd1;
            end else begin
                r_col <= acc_x + AW'(1);
            end
        end
    end

    // ---------------- line buffer memory: {above, middle} ----------------
    logic [2*PW-1:0]  mem [MAX_ROW_WIDTH];
    logic [2*PW-1:0]  r_rd;
    logic             r_byp;
    logic [2*PW-1:0]  r_byp_data;
    logic [2*PW-1:0]  wr_data;
    logic [PW-1:0]    top_x;
    logic [PW-1:0]    mid_x;

    // stage 1 (memory data available)
    logic              r_s1_valid;
    logic [AW-1:0]     r_s1_x;
    logic [PW-1:0]     r_s1_pix;
    logic              r_s1_last;
    logic              r_s1_edge_ok;
    logic              s1_adv;
    logic              s1_has_res;
    logic              out_free;

    // output register
    logic              r_out_valid;
    logic [PW-1:0]     r_out_pix;
    logic              r_out_last;

    assign wr_data = {mid_x, r_s1_pix};

    always_ff @(posedge i_clk) begin
        if (s1_adv) mem[r_s1_x] <= wr_data;
        if (s_acc) begin
            r_rd       <= mem[acc_x];
            // read and write of the same column in one cycle: take the new data
            r_byp      <= s1_adv && (r_s1_x == acc_x);
            r_byp_data <= wr_data;
        end
    end

    assign top_x = r_byp ? r_byp_data[2*PW-1:PW] : r_rd[2*PW-1:PW];
    assign mid_x = r_byp ? r_byp_data[PW-1:0]    : r_rd[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_x       <= acc_x;
            r_s1_pix     <= i_s_tdata[PW-1:0];
            r_s1_last    <= i_s_tlast;
            r_s1_edge_ok <= acc_edge_ok;
        end
    end

    // ---------------- 3x2 window: [0..2] column x-1, [3..5] column x-2 ----------------
    logic [PW-1:0] r_win [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_win[i] <= '0;
        end else if (s1_adv) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= top_x;
            r_win[1] <= mid_x;
            r_win[2] <= r_s1_pix;
        end
    end

    // ---------------- offset computation ----------------
    logic [PW-1:0]     ea, eb, ec;
    logic              lt_a, gt_a, lt_b, gt_b, eq_a, eq_b;
    logic [4:0]        band_k;
    logic [1:0]        ofs_idx;
    logic              ofs_en;
    logic [PW-1:0]     base;
    logic signed [PW+1:0] sum;
    logic [PW-1:0]     res_pix;

    always_comb begin
        case (sao_pkg::t_edge_class'(r_edge_class))
            sao_pkg::EDGE_HOR: begin ea = r_win[4]; eb = mid_x;    end
            sao_pkg::EDGE_VER: begin ea = r_win[0]; eb = r_win[2]; end
            sao_pkg::EDGE_DR:  begin ea = r_win[3]; eb = r_s1_pix; end
            default:           begin ea = top_x;    eb = r_win[5]; end
        endcase
        ec   = r_win[1];
        lt_a = ec < ea;
        gt_a = ec > ea;
        eq_a = ec == ea;
        lt_b = ec < eb;
        gt_b = ec > eb;
        eq_b = ec == eb;
        band_k = (5'(r_s1_pix >> sao_pkg::BAND_SHIFT) & sao_pkg::BAND_MASK) - r_band_start;

        if (!r_mode) begin
            base    = r_s1_pix;
            ofs_en  = band_k < 5'd4;
            ofs_idx = band_k[1:0];
        end else begin
            base = ec;
            ofs_en = 1'b1;
            if (lt_a && lt_b) begin
                ofs_idx = 2'd0;
            end else if ((lt_a && eq_b) || (eq_a && lt_b)) begin
                ofs_idx = 2'd1;
            end else if ((gt_a && eq_b) || (eq_a && gt_b)) begin
                ofs_idx = 2'd2;
            end else if (gt_a && gt_b) begin
                ofs_idx = 2'd3;
            end else begin
                ofs_idx = 2'd0;
                ofs_en  = 1'b0;
            end
        end

        sum = $signed({2'b00, base});
        if (ofs_en) sum = sum + (PW+2)'(r_offset[ofs_idx]);

        if (sum < 0) begin
            res_pix = '0;
        end else if (sum > $signed({2'b00, sao_pkg::PIX_MAX})) begin
            res_pix = sao_pkg::PIX_MAX;
        end else begin
            res_pix = sum[PW-1:0];
        end
    end

    // ---------------- handshake ----------------
    assign s1_has_res = !r_mode || r_s1_edge_ok;
    assign out_free   = !r_out_valid || i_m_tready;
    assign s1_adv     = r_s1_valid && (!s1_has_res || out_free);
    assign o_s_tready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && s1_has_res) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_has_res) begin
            r_out_pix  <= res_pix;
            r_out_last <= r_s1_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_pix};
    assign o_m_tlast  = r_out_last;

    // ---------------- assertions ----------------
    a_row_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row != 2'd3)
        else $error("row counter passed saturation");

    a_band_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_mode) |-> s1_has_res)
        else $error("band mode word without result");

    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(r_out_pix)))
        else $error("stalled result overwritten or dropped");

    a_bypass_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s1_adv && (r_s1_x == acc_x)) |=> r_byp)
        else $error("same-column forwarding missed");

endmodule

// File: sim/sample_adaptive_offset_filter_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sample_adaptive_offset_filter_unit: band and edge offset
// streams are checked word by word against an in-bench predictor of the filter.
// Depends on sao_pkg and the unit RTL.
module sample_adaptive_offset_filter_unit_tb;
    import sao_pkg::*;

    localparam int MAX_W          = 256;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 100;
    localparam bit MODE_BAND      = 1'b0;
    localparam bit MODE_EDGE      = 1'b1;
    // edge categories: sign(c-a) + sign(c-b)
    localparam int CAT_VALLEY     = -2;
    localparam int CAT_CONCAVE    = -1;
    localparam int CAT_CONVEX     = 1;
    localparam int CAT_PEAK       = 2;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             last;
    } sao_word_t;

    class sao_filter_predictor;
        bit               mode;
        t_edge_class      eclass;
        logic [4:0]       band_start;
        t_offset          ofs [NUM_OFS];
        logic [8:0]       row_width;
        logic [PIX_W-1:0] line_above [MAX_W];
        logic [PIX_W-1:0] line_middle [MAX_W];
        logic [PIX_W-1:0] win [6];   // 0..2 column x-1 (top, mid, bottom), 3..5 column x-2
        int               col;
        int               rows;
        sao_word_t        corrected_q [$];
        int               n_checked;
        int               n_edge;
        int               n_band;
        int               n_errors;

        function new();
            mode       = MODE_BAND;
            eclass     = EDGE_HOR;
            band_start = '0;
            row_width  = 9'd256;
            foreach (ofs[i]) ofs[i] = '0;
            foreach (line_above[i]) begin
                line_above[i]  = '0;
                line_middle[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            col       = 0;
            rows      = 0;
            n_checked = 0;
            n_edge    = 0;
            n_band    = 0;
            n_errors  = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] v);
            case (idx)
                REG_SAO_MODE:    mode       = v[0];
                REG_EDGE_CLASS:  eclass     = t_edge_class'(v[1:0]);
                REG_BAND_START:  band_start = v[4:0];
                REG_OFFSET_CAT0: ofs[0]     = v[7:0];
                REG_OFFSET_CAT1: ofs[1]     = v[7:0];
                REG_OFFSET_CAT2: ofs[2]     = v[7:0];
                REG_OFFSET_CAT3: ofs[3]     = v[7:0];
                REG_ROW_WIDTH:   row_width  = v[8:0];
                default: ;
            endcase
        endfunction

        function int sgn(int d);
            return int'(d > 0) - int'(d < 0);
        endfunction

        function logic [PIX_W-1:0] clip_sample(int v);
            if (v < 0) return '0;
            if (v > int'(PIX_MAX)) return PIX_MAX;
            return PIX_W'(v);
        endfunction

        function void note_sample(logic [PIX_W-1:0] pix, logic last);
            int               w;
            int               x;
            int               a;
            int               b;
            int               c;
            int               cat;
            int               v;
            logic [4:0]       k;
            logic [PIX_W-1:0] top_x;
            logic [PIX_W-1:0] mid_x;
            sao_word_t        r;
            w = (row_width < 3) ? 3 : ((row_width > MAX_W) ? MAX_W : int'(row_width));
            // a column at or past a shrunk width counts as the last one of the row
            x = (col >= w) ? w - 1 : col;
            top_x  = line_above[x];
            mid_x  = line_middle[x];
            r.last = last;
            if (mode == MODE_BAND) begin
                k = 5'(pix >> BAND_SHIFT) - band_start;
                v = int'(pix);
                if (k < NUM_OFS) v += int'(ofs[k]);
                r.pix = clip_sample(v);
                corrected_q.push_back(r);
                n_band++;
            end else if (rows >= 2 && x >= 2) begin
                c = int'(win[1]);
                case (eclass)
                    EDGE_HOR: begin a = int'(win[4]); b = int'(mid_x); end
                    EDGE_VER: begin a = int'(win[0]); b = int'(win[2]); end
                    EDGE_DR:  begin a = int'(win[3]); b = int'(pix);   end
                    default:  begin a = int'(top_x);  b = int'(win[5]); end
                endcase
                cat = sgn(c - a) + sgn(c - b);
                v = c;
                case (cat)
                    CAT_VALLEY:  v += int'(ofs[0]);
                    CAT_CONCAVE: v += int'(ofs[1]);
                    CAT_CONVEX:  v += int'(ofs[2]);
                    CAT_PEAK:    v += int'(ofs[3]);
                    default: ;
                endcase
                r.pix = clip_sample(v);
                corrected_q.push_back(r);
                n_edge++;
            end
            win[3] = win[0];
            win[4] = win[1];
            win[5] = win[2];
            win[0] = top_x;
            win[1] = mid_x;
            win[2] = pix;
            line_above[x]  = mid_x;
            line_middle[x] = pix;
            if (last) begin
                col  = 0;
                rows = 0;
            end else if (x + 1 >= w) begin
                col = 0;
                if (rows < 2) rows++;
            end else begin
                col = x + 1;
            end
        endfunction

        task report(string msg);
            n_errors++;
            if (n_errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check_sample(logic [PIX_W-1:0] pix, logic last);
            sao_word_t r;
            n_checked++;
            if (corrected_q.size() == 0) begin
                report($sformatf("unexpected word pixel_out=%0d result_last=%0b", pix, last));
            end else begin
                r = corrected_q.pop_front();
                if (pix !== r.pix)
                    report($sformatf("pixel_out %0d, expected %0d", pix, r.pix));
                if (last !== r.last)
                    report($sformatf("result_last %0b, expected %0b", last, r.last));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [15:0] i_s_tdata  = '0;    // [9:0] pixel_in, [15:10] zero
    logic        i_s_tlast  = 1'b0;  // block_end
    logic        i_m_tready = 1'b0;
    logic        i_psel     = 1'b0;
    logic        i_penable  = 1'b0;
    logic        i_pwrite   = 1'b0;
    logic [4:0]  i_paddr    = '0;
    logic [31:0] i_pwdata   = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;          // [9:0] pixel_out, [15:10] zero
    logic        o_m_tlast;          // result_last
    logic [31:0] o_prdata;
    logic        o_pready;

    sao_filter_predictor sao_pred;
    int tx_idle_pct;
    int rx_idle_pct;
    int n_sent;
    int n_blocks;
    int idle_cycles = 0;

    sample_adaptive_offset_filter_unit #(
        .MAX_ROW_WIDTH(MAX_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: check accepted words, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sao_pred.check_sample(o_m_tdata[PIX_W-1:0], o_m_tlast);
        i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_word(input logic [PIX_W-1:0] pix, input logic last);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'd0, pix};
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        sao_pred.note_sample(pix, last);
        n_sent++;
        if (last) n_blocks++;
    endtask

    // drop valid, then wait for the last result and let border words flush
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sao_pred.corrected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= val;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        sao_pred.set_reg(idx, val);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_filter(input bit mode, input t_edge_class cls, input int bstart,
                                  input int o0, input int o1, input int o2, input int o3,
                                  input int width);
        reg_write(REG_SAO_MODE, 32'(mode));
        reg_write(REG_EDGE_CLASS, 32'(cls));
        reg_write(REG_BAND_START, 32'(bstart & 31));
        reg_write(REG_OFFSET_CAT0, 32'(o0 & 255));
        reg_write(REG_OFFSET_CAT1, 32'(o1 & 255));
        reg_write(REG_OFFSET_CAT2, 32'(o2 & 255));
        reg_write(REG_OFFSET_CAT3, 32'(o3 & 255));
        reg_write(REG_ROW_WIDTH, 32'(width & 511));
    endtask

    function automatic int rand_offset();
        case ($urandom_range(9))
            0:          return -128;
            1:          return 127;
            2, 3, 4, 5: return int'($urandom_range(16)) - 8;
            default:    return int'($urandom_range(255)) - 128;
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] texture_pixel(int base, int spread);
        int v;
        v = base + int'($urandom_range(2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return PIX_W'(v);
    endfunction

    // padded block in raster order; a broken block may end early at a random word
    task automatic send_edge_block(input int w, input int h, input bit broken);
        int total;
        int cut;
        int base;
        int spread;
        total = w * h;
        cut   = broken ? int'($urandom_range(total - 1)) + 1 : total;
        case ($urandom_range(9))
            0:       base = 0;
            1:       base = 1023;
            default: base = int'($urandom_range(1023));
        endcase
        case ($urandom_range(4))
            0:       spread = 1;
            1:       spread = 2;
            2:       spread = 6;
            3:       spread = 40;
            default: spread = 1023;
        endcase
        for (int i = 0; i < cut; i++)
            send_word(texture_pixel(base, spread), i == cut - 1);
    endtask

    // half the samples land in or right next to the four offset bands
    task automatic send_band_block(input int len);
        logic [PIX_W-1:0] pix;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(1))
                pix = {5'(sao_pred.band_start + 5'($urandom_range(4))), 5'($urandom_range(31))};
            else
                pix = PIX_W'($urandom_range(1023));
            send_word(pix, i == len - 1);
        end
    endtask

    task automatic random_phase(input bit widest);
        bit edge_mode;
        int w;
        int eff;
        int nblk;
        edge_mode = widest || ($urandom_range(99) < 65);
        if (widest)
            w = 511;
        else if (edge_mode)
            case ($urandom_range(11))
                0:       w = int'($urandom_range(2));
                1, 2:    w = int'($urandom_range(13, 40));
                default: w = int'($urandom_range(3, 12));
            endcase
        else
            w = ($urandom_range(4) == 0) ? int'($urandom_range(257, 511))
                                         : int'($urandom_range(3, 64));
        program_filter(edge_mode, t_edge_class'($urandom_range(3)), int'($urandom_range(31)),
                       rand_offset(), rand_offset(), rand_offset(), rand_offset(), w);
        eff  = (w < 3) ? 3 : ((w > MAX_W) ? MAX_W : w);
        nblk = widest ? 1 : int'($urandom_range(1, 4));
        repeat (nblk) begin
            if (edge_mode)
                send_edge_block(eff, widest ? 3 : int'($urandom_range(2, 6)),
                                !widest && ($urandom_range(99) < 15));
            else
                send_band_block(int'($urandom_range(1, 60)));
        end
        drain();
    endtask

    initial begin
        int seg_target [3];
        sao_pred    = new();
        tx_idle_pct = 37;
        rx_idle_pct = 59;
        n_sent      = 0;
        n_blocks    = 0;
        seg_target  = '{400, 800, 1550};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // band offsets at the extremes, band window wrapping from 31 to 2
        program_filter(MODE_BAND, EDGE_HOR, 31, 127, -128, -1, 5, 300);
        send_word(10'd1023, 1'b0);
        send_word(10'd0, 1'b0);
        send_word(10'd40, 1'b0);
        send_word(10'd64, 1'b0);
        send_word(10'd100, 1'b0);
        send_word(10'd512, 1'b1);
        drain();

        // width below range clamps to 3: one interior sample, a local minimum on the
        // down-left diagonal; then a one-word block ending on a border word
        program_filter(MODE_EDGE, EDGE_DL, 0, 20, -3, 3, -20, 1);
        send_word(10'd9, 1'b0);
        send_word(10'd9, 1'b0);
        send_word(10'd700, 1'b0);
        send_word(10'd9, 1'b0);
        send_word(10'd5, 1'b0);
        send_word(10'd9, 1'b0);
        send_word(10'd900, 1'b0);
        send_word(10'd9, 1'b0);
        send_word(10'd9, 1'b1);
        send_word(10'd1023, 1'b1);
        drain();

        // band words in a row of width 6, then switch to edge mode and shrink the width in the middle of that row
        program_filter(MODE_BAND, EDGE_VER, 0, 127, 127, 127, 127, 6);
        send_word(10'd10, 1'b0);
        send_word(10'd20, 1'b0);
        send_word(10'd1000, 1'b0);
        send_word(10'd30, 1'b0);
        drain();
        reg_write(REG_SAO_MODE, 32'(MODE_EDGE));
        reg_write(REG_ROW_WIDTH, 32'd3);
        send_word(10'd800, 1'b0);
        send_word(10'd40, 1'b0);
        send_word(10'd1023, 1'b0);
        send_word(10'd50, 1'b0);
        send_word(10'd40, 1'b0);
        send_word(10'd60, 1'b0);
        send_word(10'd90, 1'b1);
        drain();

        for (int seg = 0; seg < 3; seg++) begin
            case (seg)
                0:       begin tx_idle_pct = 37; rx_idle_pct = 59; end
                1:       begin tx_idle_pct = 59; rx_idle_pct = 37; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            if (seg == 2) random_phase(1'b1);
            while (n_sent < seg_target[seg]) random_phase(1'b0);
        end

        drain();
        repeat (4) @(posedge i_clk);
        $display("Streamed %0d samples in %0d blocks: band and edge modes, all edge classes,",
                 n_sent, n_blocks);
        $display("widths from clamped 3 up to 256; checked %0d words (%0d band, %0d edge)",
                 sao_pred.n_checked, sao_pred.n_band, sao_pred.n_edge);
        if (sao_pred.n_errors == 0 && sao_pred.corrected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
